@@ hdl/mesh_route_table_assert.svh @@
// assertion macros shared by the route table rtl
`ifndef MESH_ROUTE_TABLE_ASSERT_SVH
`define MESH_ROUTE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define MRT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("route table assertion failed");
`define MRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error("route table assertion failed");
`else
`define MRT_ASSERT_IMP(label, clk, rst, ante, cons)
`define MRT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hdl/mrt_pkg.sv @@
// types, constants and helpers of the mesh route table
`timescale 1ns / 1ps
`default_nettype none
package mrt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   localparam int FUNC_W    = 3;
   localparam int ADDR_W    = 32;
   localparam int HOPS_W    = 16;
   localparam int FRESH_W   = 16;
   localparam int OUT_CNT_W = 7;
   localparam int STATUS_W  = 2;

   localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd0;
   localparam logic [FUNC_W-1:0] FN_ADD    = 3'd1;
   localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
   localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd3;
   localparam logic [FUNC_W-1:0] FN_COUNT  = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [ADDR_W-1:0]  dest_addr;
      logic [ADDR_W-1:0]  relay_addr;
      logic [HOPS_W-1:0]  hop_count;
      logic [FRESH_W-1:0] freshness;
   } cmd_type;

   // running result handed from cell to cell
   typedef struct packed {
      logic               found;
      logic [ADDR_W-1:0]  hop;
      logic [HOPS_W-1:0]  hops;
      logic [FRESH_W-1:0] fresh;
      logic [CNT_W-1:0]   removed;
      logic               free_found;
      logic [IDX_W-1:0]   free_idx;
   } acc_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
   } fill_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_REPLY
   } state_type;

   function automatic logic [OUT_CNT_W-1:0] to_out_cnt(input logic [CNT_W-1:0] v);
      logic [CNT_W+OUT_CNT_W-1:0] wide;
      wide = {{OUT_CNT_W{1'b0}}, v};
      return wide[OUT_CNT_W-1:0];
   endfunction

endpackage
`default_nettype wire

@@ hdl/mrt_req_if.sv @@
// request channel of the mesh route table
`timescale 1ns / 1ps
`default_nettype none
interface mrt_req_if import mrt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [ADDR_W-1:0]  dest_addr;
   logic [ADDR_W-1:0]  relay_addr;
   logic [HOPS_W-1:0]  hop_count;
   logic [FRESH_W-1:0] freshness;

   modport source (output valid, func, dest_addr, relay_addr, hop_count, freshness,
                   input ready);
   modport sink   (input valid, func, dest_addr, relay_addr, hop_count, freshness,
                   output ready);
endinterface
`default_nettype wire

@@ hdl/mrt_rsp_if.sv @@
// response channel of the mesh route table
`timescale 1ns / 1ps
`default_nettype none
interface mrt_rsp_if import mrt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 found;
   logic [ADDR_W-1:0]    hop_of_entry;
   logic [HOPS_W-1:0]    hops_of_entry;
   logic [FRESH_W-1:0]   fresh_of_entry;
   logic [OUT_CNT_W-1:0] removed;
   logic [OUT_CNT_W-1:0] entry_count;
   logic [STATUS_W-1:0]  status;

   modport source (output valid, found, hop_of_entry, hops_of_entry, fresh_of_entry,
                          removed, entry_count, status,
                   input ready);
   modport sink   (input valid, found, hop_of_entry, hops_of_entry, fresh_of_entry,
                         removed, entry_count, status,
                   output ready);
endinterface
`default_nettype wire

@@ hdl/mesh_route_table.sv @@
// mesh route table top level: chain of slot cells, control sequencer, response register
//
// req_ch carries one operation (lookup, add or update, delete, clear by next hop,
// count) with its destination, next hop, hop count and freshness. rsp_ch returns
// exactly one item per request, in order.
// A request is taken only while the block is idle. A one-hot token then walks the
// chain of TABLE_ENTRIES cells, one cell per cycle, and each cell applies the
// operation to its own entry and passes the running result on. The commit state
// then inserts a new entry into the lowest free slot when an add found no match,
// and updates the entry count. After accept, the start register launches the token,
// the cells pass it down the chain, the commit and reply states follow, and the
// response register is loaded; only then does the block take a new request.
// The response sits in an output register; the block accepts the next request
// while it waits, and a stalled receiver holds the following result back.
// Synchronous reset empties the table (all slots invalid, count zero) and drops
// any pending response; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "mesh_route_table_assert.svh"
module mesh_route_table import mrt_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   mrt_req_if.sink  req_ch,
   mrt_rsp_if.source rsp_ch
);

   state_type          state_ff, state_in;
   cmd_type            cmd_ff;
   logic               start_ff;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic [ADDR_W-1:0]    rsp_hop_ff;
   logic [HOPS_W-1:0]    rsp_hops_ff;
   logic [FRESH_W-1:0]   rsp_fresh_ff;
   logic [OUT_CNT_W-1:0] rsp_removed_ff;
   logic [OUT_CNT_W-1:0] rsp_count_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;

   logic                     req_ready;
   logic                     accept;
   logic                     commit;
   logic                     load_rsp;
   logic                     slot_free;
   logic [TABLE_ENTRIES-1:0] tok_w;
   acc_type                  acc_w [TABLE_ENTRIES];
   acc_type                  last_acc;
   fill_type                 fill;
   logic [STATUS_W-1:0]      status_nx;

   // scan chain
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      logic    tok_prev;
      acc_type acc_prev;
      if (i == 0) begin : g_head
         assign tok_prev = start_ff;
         assign acc_prev = '0;
      end else begin : g_link
         assign tok_prev = tok_w[i-1];
         assign acc_prev = acc_w[i-1];
      end
      mrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .idx     (IDX_W'(i)),
         .cmd     (cmd_ff),
         .tok_in  (tok_prev),
         .acc_in  (acc_prev),
         .fill    (fill),
         .tok_out (tok_w[i]),
         .acc_out (acc_w[i])
      );
   end

   assign last_acc  = acc_w[TABLE_ENTRIES-1];
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign accept    = req_ch.valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_SCAN;
         ST_SCAN:   if (tok_w[TABLE_ENTRIES-1]) state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_REPLY;
         ST_REPLY:  if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   ;
         ST_COMMIT: commit = 1'b1;
         ST_REPLY:  load_rsp = slot_free;
         default:   ;
      endcase
   end

   assign fill.en  = commit && (cmd_ff.func == FN_ADD) && !last_acc.found
                     && last_acc.free_found;
   assign fill.idx = last_acc.free_idx;

   always_comb begin
      count_in = count_ff;
      if (commit) begin
         count_in = count_ff + CNT_W'(fill.en) - last_acc.removed;
      end
   end

   always_comb begin
      case (cmd_ff.func)
         FN_LOOKUP, FN_DELETE: status_nx = last_acc.found ? STAT_OK : STAT_MISS;
         FN_ADD: status_nx = (last_acc.found || last_acc.free_found) ? STAT_OK
                                                                     : STAT_FULL;
         default: status_nx = STAT_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= accept;
         count_ff <= count_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff.func       <= req_ch.func;
         cmd_ff.dest_addr  <= req_ch.dest_addr;
         cmd_ff.relay_addr <= req_ch.relay_addr;
         cmd_ff.hop_count  <= req_ch.hop_count;
         cmd_ff.freshness  <= req_ch.freshness;
      end
      if (load_rsp) begin
         rsp_found_ff   <= last_acc.found;
         rsp_hop_ff     <= last_acc.hop;
         rsp_hops_ff    <= last_acc.hops;
         rsp_fresh_ff   <= last_acc.fresh;
         rsp_removed_ff <= to_out_cnt(last_acc.removed);
         rsp_count_ff   <= to_out_cnt(count_ff);
         rsp_status_ff  <= status_nx;
      end
   end

   assign req_ch.ready          = req_ready;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.found          = rsp_found_ff;
   assign rsp_ch.hop_of_entry   = rsp_hop_ff;
   assign rsp_ch.hops_of_entry  = rsp_hops_ff;
   assign rsp_ch.fresh_of_entry = rsp_fresh_ff;
   assign rsp_ch.removed        = rsp_removed_ff;
   assign rsp_ch.entry_count    = rsp_count_ff;
   assign rsp_ch.status         = rsp_status_ff;

   `MRT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_ENTRIES))
   `MRT_ASSERT_IMP(a_token_single, clock, reset, 1'b1, $onehot0(tok_w))
   `MRT_ASSERT_IMP(a_token_trip, clock, reset, start_ff, ##TABLE_ENTRIES tok_w[TABLE_ENTRIES-1])
   `MRT_ASSERT_IMP(a_remove_bound, clock, reset, commit, last_acc.removed <= count_ff)
   `MRT_ASSERT_NEXT(a_no_take_busy, clock, reset, accept, !req_ready)

endmodule
`default_nettype wire

@@ hdl/mrt_cell.sv @@
// one route table slot: stored entry plus one stage of the scan chain
`timescale 1ns / 1ps
`default_nettype none
module mrt_cell import mrt_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] idx,
   input  wire cmd_type          cmd,
   input  wire logic             tok_in,
   input  wire acc_type          acc_in,
   input  wire fill_type         fill,
   output logic                  tok_out,
   output acc_type               acc_out
);

   logic               valid_ff, valid_in;
   logic [ADDR_W-1:0]  dest_ff, dest_in;
   logic [ADDR_W-1:0]  hop_ff, hop_in;
   logic [HOPS_W-1:0]  hops_ff, hops_in;
   logic [FRESH_W-1:0] fresh_ff, fresh_in;
   logic               tok_ff;
   acc_type            acc_ff, acc_in_nx;
   logic               match;

   assign match = valid_ff && (dest_ff == cmd.dest_addr);

   always_comb begin
      valid_in  = valid_ff;
      dest_in   = dest_ff;
      hop_in    = hop_ff;
      hops_in   = hops_ff;
      fresh_in  = fresh_ff;
      acc_in_nx = acc_in;
      if (tok_in) begin
         case (cmd.func)
            FN_LOOKUP: begin
               if (match) begin
                  acc_in_nx.found = 1'b1;
                  acc_in_nx.hop   = hop_ff;
                  acc_in_nx.hops  = hops_ff;
                  acc_in_nx.fresh = fresh_ff;
               end
            end
            FN_ADD: begin
               if (match) begin
                  acc_in_nx.found = 1'b1;
                  if (fresh_ff < cmd.freshness) begin
                     hop_in   = cmd.relay_addr;
                     hops_in  = cmd.hop_count;
                     fresh_in = cmd.freshness;
                  end
               end else if (!valid_ff && !acc_in.free_found) begin
                  // lowest free slot wins, the insert happens after the scan
                  acc_in_nx.free_found = 1'b1;
                  acc_in_nx.free_idx   = idx;
               end
            end
            FN_DELETE: begin
               if (match) begin
                  valid_in          = 1'b0;
                  acc_in_nx.found   = 1'b1;
                  acc_in_nx.removed = acc_in.removed + CNT_W'(1);
               end
            end
            FN_CLEAR: begin
               if (valid_ff && (hop_ff == cmd.relay_addr)) begin
                  valid_in          = 1'b0;
                  acc_in_nx.removed = acc_in.removed + CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
      if (fill.en && (fill.idx == idx)) begin
         valid_in = 1'b1;
         dest_in  = cmd.dest_addr;
         hop_in   = cmd.relay_addr;
         hops_in  = cmd.hop_count;
         fresh_in = cmd.freshness;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      dest_ff  <= dest_in;
      hop_ff   <= hop_in;
      hops_ff  <= hops_in;
      fresh_ff <= fresh_in;
      if (tok_in) begin
         acc_ff <= acc_in_nx;
      end
   end

   assign tok_out = tok_ff;
   assign acc_out = acc_ff;

endmodule
`default_nettype wire
